@@ rtl/core/cau_pkg.sv @@
`timescale 1ns / 1ps
package cau_pkg;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_EQ  = 3'd4,
    MODE_NE  = 3'd5
  } mode_t;

  typedef struct packed {
    logic        [2:0]  mode;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               cmp_flag;
    logic               div_zero;
    logic               saturated;
  } out_item_t;

endpackage

@@ rtl/core/complex_arith_unit.sv @@
`timescale 1ns / 1ps
// Complex ALU on signed fixed-point parts (add, subtract, multiply, divide, compare), fully
// pipelined: one item per cycle while the output is not stalled. Most of the depth is the
// divider, a restoring divider of 33 quotient-bit stages, one stage per bit; multiply and
// divide share four 32x32 products in the second stage, divide adding two squares. Empty
// stages close up under stall, so items keep entering while a result waits at the output.
module complex_arith_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int EW   = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 2) ? 2 : DATA_WIDTH);
  localparam int EF   = (FRAC_BITS > 31) ? 31 : ((FRAC_BITS < 0) ? 0 : FRAC_BITS);
  localparam int NDIV = 33;
  localparam logic [63:0] LIM = 64'(1) << (EW - 1);
  localparam logic [64:0] RND = (65'(1) << EF) - 65'(1);

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
    logic        ovf;
    logic [63:0] rem;
    logic [32:0] low;
    logic [32:0] q;
  } part_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        eq;
    logic        dz;
    logic [63:0] den;
    part_t       re;
    part_t       im;
  } dv_t;

  function automatic logic signed [31:0] sext(input logic [31:0] x);
    logic [31:0] t;
    t = x << (32 - EW);
    sext = $signed(t) >>> (32 - EW);
  endfunction

  function automatic part_t prep(input logic neg, input logic [63:0] mag,
                                 input logic [2:0] mode, input logic [63:0] den);
    part_t       p;
    logic [94:0] n;
    logic [64:0] rm;
    n  = 95'(mag) << EF;
    rm = {1'b0, mag} + RND;
    p.neg = neg;
    p.q   = '0;
    p.low = n[32:0];
    p.mag = mag;
    if (mode == MODE_MUL) begin
      p.mag = neg ? 64'(rm >> EF) : (mag >> EF);
    end
    p.ovf = (mode == MODE_DIV) && ({2'b00, n[94:33]} >= den);
    p.rem = p.ovf ? 64'd0 : {2'b00, n[94:33]};
    return p;
  endfunction

  function automatic part_t div_step(input part_t p, input logic [63:0] den);
    part_t       o;
    logic [64:0] r2;
    o  = p;
    r2 = {p.rem, p.low[32]};
    o.low = p.low << 1;
    if (r2 >= {1'b0, den}) begin
      o.rem = 64'(r2 - {1'b0, den});
      o.q   = {p.q[31:0], 1'b1};
    end else begin
      o.rem = r2[63:0];
      o.q   = {p.q[31:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [32:0] clamp(input logic neg, input logic [63:0] mag,
                                        input logic ovf);
    logic [63:0] v;
    logic        hit;
    hit = 1'b0;
    if (!neg) begin
      if (ovf || mag > LIM - 64'd1) begin
        hit = 1'b1;
        v   = LIM - 64'd1;
      end else begin
        v = mag;
      end
    end else begin
      if (ovf || mag > LIM) begin
        hit = 1'b1;
        v   = 64'd0 - LIM;
      end else begin
        v = 64'd0 - mag;
      end
    end
    return {hit, v[31:0]};
  endfunction

  // stage enables: a stage moves when it is empty or its successor moves
  logic en_a, en_b, en_c, en_d, en_o;
  logic en_dv [NDIV+1];

  // stage A: sign-extended operands
  logic               a_v_r;
  logic [2:0]         a_mode_r;
  logic signed [31:0] a_ar_r, a_ai_r, a_br_r, a_bi_r;

  // stage B: products and part-wise sums
  logic               b_v_r;
  logic [2:0]         b_mode_r;
  logic               b_eq_r, b_eq_nxt;
  logic signed [63:0] b_rr_r, b_ii_r, b_ri_r, b_ir_r, b_dr_r, b_di_r;
  logic signed [32:0] b_sre_r, b_sim_r, b_sre_nxt, b_sim_nxt;

  // stage C: exact sums and denominator
  logic               c_v_r;
  logic [2:0]         c_mode_r;
  logic               c_eq_r, c_dz_r, c_dz_nxt;
  logic signed [64:0] c_xre_r, c_xim_r, c_xre_nxt, c_xim_nxt;
  logic [63:0]        c_den_r, c_den_nxt;

  // stage D: sign and magnitude
  logic               d_v_r;
  logic [2:0]         d_mode_r;
  logic               d_eq_r, d_dz_r;
  logic [63:0]        d_den_r;
  logic               d_nre_r, d_nim_r;
  logic [63:0]        d_mre_r, d_mim_r, d_mre_nxt, d_mim_nxt;

  // divider stages: index 0 is the rounding and set-up stage
  logic dv_v_r [NDIV+1];
  dv_t  dv_r   [NDIV+1];
  dv_t  dv_nxt [NDIV+1];

  logic      out_v_r;
  out_item_t out_r, out_nxt;

  assign en_o  = !out_v_r || !out_stall;
  assign en_d  = !d_v_r || en_dv[0];
  assign en_c  = !c_v_r || en_d;
  assign en_b  = !b_v_r || en_c;
  assign en_a  = !a_v_r || en_b;
  assign in_stall = !en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en_a) begin
      a_v_r <= in_valid;
    end
    if (en_a) begin
      a_mode_r <= in_data.mode;
      a_ar_r   <= sext(in_data.a_re);
      a_ai_r   <= sext(in_data.a_im);
      a_br_r   <= sext(in_data.b_re);
      a_bi_r   <= sext(in_data.b_im);
    end
  end

  always_comb begin
    b_eq_nxt = (a_ar_r == a_br_r) && (a_ai_r == a_bi_r);
    if (a_mode_r == MODE_SUB) begin
      b_sre_nxt = 33'(a_ar_r) - 33'(a_br_r);
      b_sim_nxt = 33'(a_ai_r) - 33'(a_bi_r);
    end else begin
      b_sre_nxt = 33'(a_ar_r) + 33'(a_br_r);
      b_sim_nxt = 33'(a_ai_r) + 33'(a_bi_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en_b) begin
      b_v_r <= a_v_r;
    end
    if (en_b) begin
      b_mode_r <= a_mode_r;
      b_eq_r   <= b_eq_nxt;
      b_sre_r  <= b_sre_nxt;
      b_sim_r  <= b_sim_nxt;
      b_rr_r   <= a_ar_r * a_br_r;
      b_ii_r   <= a_ai_r * a_bi_r;
      b_ri_r   <= a_ar_r * a_bi_r;
      b_ir_r   <= a_ai_r * a_br_r;
      b_dr_r   <= a_br_r * a_br_r;
      b_di_r   <= a_bi_r * a_bi_r;
    end
  end

  always_comb begin
    c_den_nxt = 64'($unsigned(b_dr_r)) + 64'($unsigned(b_di_r));
    c_dz_nxt  = (b_mode_r == MODE_DIV) && (c_den_nxt == 64'd0);
    case (b_mode_r)
      MODE_ADD, MODE_SUB: begin
        c_xre_nxt = 65'(b_sre_r);
        c_xim_nxt = 65'(b_sim_r);
      end
      MODE_MUL: begin
        c_xre_nxt = 65'(b_rr_r) - 65'(b_ii_r);
        c_xim_nxt = 65'(b_ri_r) + 65'(b_ir_r);
      end
      MODE_DIV: begin
        c_xre_nxt = 65'(b_rr_r) + 65'(b_ii_r);
        c_xim_nxt = 65'(b_ir_r) - 65'(b_ri_r);
      end
      default: begin
        c_xre_nxt = '0;
        c_xim_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en_c) begin
      c_v_r <= b_v_r;
    end
    if (en_c) begin
      c_mode_r <= b_mode_r;
      c_eq_r   <= b_eq_r;
      c_dz_r   <= c_dz_nxt;
      c_den_r  <= c_den_nxt;
      c_xre_r  <= c_xre_nxt;
      c_xim_r  <= c_xim_nxt;
    end
  end

  always_comb begin
    d_mre_nxt = c_xre_r[64] ? 64'(-c_xre_r) : c_xre_r[63:0];
    d_mim_nxt = c_xim_r[64] ? 64'(-c_xim_r) : c_xim_r[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en_d) begin
      d_v_r <= c_v_r;
    end
    if (en_d) begin
      d_mode_r <= c_mode_r;
      d_eq_r   <= c_eq_r;
      d_dz_r   <= c_dz_r;
      d_den_r  <= c_den_r;
      d_nre_r  <= c_xre_r[64];
      d_nim_r  <= c_xim_r[64];
      d_mre_r  <= d_mre_nxt;
      d_mim_r  <= d_mim_nxt;
    end
  end

  always_comb begin
    dv_nxt[0].mode = d_mode_r;
    dv_nxt[0].eq   = d_eq_r;
    dv_nxt[0].dz   = d_dz_r;
    dv_nxt[0].den  = d_den_r;
    dv_nxt[0].re   = prep(d_nre_r, d_mre_r, d_mode_r, d_den_r);
    dv_nxt[0].im   = prep(d_nim_r, d_mim_r, d_mode_r, d_den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en_dv[0]) begin
      dv_v_r[0] <= d_v_r;
    end
    if (en_dv[0]) begin
      dv_r[0] <= dv_nxt[0];
    end
  end

  assign en_dv[0]    = !dv_v_r[0] || en_dv[1];
  assign en_dv[NDIV] = !dv_v_r[NDIV] || en_o;

  // one quotient bit per stage, both parts side by side
  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    if (k < NDIV) begin : g_en
      assign en_dv[k] = !dv_v_r[k] || en_dv[k+1];
    end

    always_comb begin
      dv_nxt[k]    = dv_r[k-1];
      dv_nxt[k].re = div_step(dv_r[k-1].re, dv_r[k-1].den);
      dv_nxt[k].im = div_step(dv_r[k-1].im, dv_r[k-1].den);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (en_dv[k]) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
      if (en_dv[k]) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  always_comb begin
    logic [32:0] cre, cim;
    dv_t         f;
    f = dv_r[NDIV];
    if (f.mode == MODE_DIV) begin
      cre = clamp(f.re.neg, 64'(f.re.q), f.re.ovf);
      cim = clamp(f.im.neg, 64'(f.im.q), f.im.ovf);
    end else begin
      cre = clamp(f.re.neg, f.re.mag, 1'b0);
      cim = clamp(f.im.neg, f.im.mag, 1'b0);
    end
    out_nxt = '0;
    case (f.mode)
      MODE_ADD, MODE_SUB, MODE_MUL: begin
        out_nxt.res_re    = cre[31:0];
        out_nxt.res_im    = cim[31:0];
        out_nxt.saturated = cre[32] | cim[32];
      end
      MODE_DIV: begin
        if (f.dz) begin
          out_nxt.div_zero = 1'b1;
        end else begin
          out_nxt.res_re    = cre[31:0];
          out_nxt.res_im    = cim[31:0];
          out_nxt.saturated = cre[32] | cim[32];
        end
      end
      MODE_EQ: out_nxt.cmp_flag = f.eq;
      MODE_NE: out_nxt.cmp_flag = !f.eq;
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_o) begin
      out_v_r <= dv_v_r[NDIV];
    end
    if (en_o) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_v_r && b_v_r && out_v_r && out_stall)
    else $error("input stalled with an empty stage");

  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_zero |->
      out_data.res_re == 32'sd0 && out_data.res_im == 32'sd0 && !out_data.saturated
      && !out_data.cmp_flag)
    else $error("divide-by-zero item carries a value");

  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cmp_flag |->
      out_data.res_re == 32'sd0 && out_data.res_im == 32'sd0 && !out_data.saturated)
    else $error("compare item carries a value");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !a_v_r)
    else $error("pipeline not empty after reset");

endmodule
